[rtl/core/rsbm_pkg.sv]
// ----------------------------------------------------------------------------
// rsbm_pkg
// Shared types and constants for the raw socket best-match demux.
// ----------------------------------------------------------------------------
package rsbm_pkg;

    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int LEVEL_W = 3;
    localparam int SLOT_W  = 3;

    // item kind
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    // match levels
    localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_CATCHALL = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_PROTO    = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE_ADDR = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 3'd4;

    // entry load broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  index;
        logic               in_use;
        logic [PROTO_W-1:0] protocol;
        logic               local_set;
        logic [ADDR_W-1:0]  local_addr;
        logic               remote_set;
        logic [ADDR_W-1:0]  remote_addr;
    } t_wr;

    // lookup token passed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic [PROTO_W-1:0] proto;
        logic [LEVEL_W-1:0] level;
        logic [SLOT_W-1:0]  slot;
    } t_token;

endpackage

[rtl/core/rsbm_if.sv]
// ----------------------------------------------------------------------------
// rsbm_in_if / rsbm_out_if
// Valid/ready channels carrying the demux input and result items.
// ----------------------------------------------------------------------------
interface rsbm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  entry_index;
    logic        entry_in_use;
    logic [7:0]  entry_protocol;
    logic        entry_local_set;
    logic [31:0] entry_local_addr;
    logic        entry_remote_set;
    logic [31:0] entry_remote_addr;
    logic [31:0] pkt_src_addr;
    logic [31:0] pkt_dst_addr;
    logic [7:0]  pkt_protocol;

    modport source (
        output valid, kind, entry_index, entry_in_use, entry_protocol,
               entry_local_set, entry_local_addr, entry_remote_set,
               entry_remote_addr, pkt_src_addr, pkt_dst_addr, pkt_protocol,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_in_use, entry_protocol,
               entry_local_set, entry_local_addr, entry_remote_set,
               entry_remote_addr, pkt_src_addr, pkt_dst_addr, pkt_protocol,
        output ready
    );
endinterface

interface rsbm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] match_level;
    logic [2:0] match_slot;

    modport source (output valid, match_level, match_slot, input ready);
    modport sink   (input valid, match_level, match_slot, output ready);
endinterface

[rtl/core/raw_socket_best_match_demux_unit.sv]
// ----------------------------------------------------------------------------
// raw_socket_best_match_demux_unit
// Socket table with best-match lookup, one cell per slot in a chain.
// ----------------------------------------------------------------------------
// Lookup: the token is registered in each cell in turn as it walks the chain,
// and the result is then registered at the output; the chain holds while a
// finished result cannot leave. A write is registered into its cell directly.
// Input: closed from the taking of a lookup until its result is registered
// at the output; writes are taken every cycle while no lookup is in the chain.
// Reset: clears every slot's in-use flag, the chain, the busy flag and the output valid flag.
module raw_socket_best_match_demux_unit
    import rsbm_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsbm_in_if.sink           i_in,
    rsbm_out_if.source        o_out
);

    t_token             tok [NUM_SLOTS+1];
    logic [NUM_SLOTS:0] tok_valid;
    t_wr                wr;
    logic               in_acc;
    logic               adv;
    logic               done;

    logic               r_busy;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic [SLOT_W-1:0]  r_slot;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_busy;

    assign wr.en          = in_acc && (i_in.kind == KIND_WRITE);
    assign wr.index       = i_in.entry_index;
    assign wr.in_use      = i_in.entry_in_use;
    assign wr.protocol    = i_in.entry_protocol;
    assign wr.local_set   = i_in.entry_local_set;
    assign wr.local_addr  = i_in.entry_local_addr;
    assign wr.remote_set  = i_in.entry_remote_set;
    assign wr.remote_addr = i_in.entry_remote_addr;

    assign tok[0].valid = in_acc && (i_in.kind == KIND_LOOKUP);
    assign tok[0].src   = i_in.pkt_src_addr;
    assign tok[0].dst   = i_in.pkt_dst_addr;
    assign tok[0].proto = i_in.pkt_protocol;
    assign tok[0].level = LEVEL_NONE;
    assign tok[0].slot  = '0;

    // hold the chain while a finished result cannot leave
    assign adv  = !(tok[NUM_SLOTS].valid && r_out_valid && !o_out.ready);
    assign done = tok[NUM_SLOTS].valid && adv;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            rsbm_cell #(
                .SLOT_ID (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_wr    (wr),
                .i_tok   (tok[g]),
                .o_tok   (tok[g+1])
            );
        end
        for (g = 0; g <= NUM_SLOTS; g++) begin : g_tv
            assign tok_valid[g] = tok[g].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (tok[0].valid) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_level <= tok[NUM_SLOTS].level;
            r_slot  <= tok[NUM_SLOTS].slot;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.match_level = r_level;
    assign o_out.match_slot  = r_slot;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_valid))
        else $error("more than one lookup token in the chain");

    a_busy_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[0].valid |=> r_busy)
        else $error("lookup taken but block not marked busy");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_level <= LEVEL_FULL))
        else $error("match level out of range");

    a_no_match_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_level == LEVEL_NONE)) |-> (r_slot == '0))
        else $error("slot set without a match");

endmodule

[rtl/core/rsbm_cell.sv]
// ----------------------------------------------------------------------------
// rsbm_cell
// One socket table slot: holds the entry and grades the passing lookup token.
// ----------------------------------------------------------------------------
module rsbm_cell
    import rsbm_pkg::*;
#(
    parameter int SLOT_ID = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_wr    i_wr,
    input  t_token i_tok,
    output t_token o_tok
);

    logic               r_valid;
    logic [PROTO_W-1:0] r_proto;
    logic               r_loc_set;
    logic [ADDR_W-1:0]  r_loc_addr;
    logic               r_rem_set;
    logic [ADDR_W-1:0]  r_rem_addr;
    t_token             r_tok;
    t_token             n_tok;

    logic               wr_hit;
    logic               proto_eq;
    logic               loc_hit;
    logic               rem_hit;
    logic               no_addr;
    logic [LEVEL_W-1:0] level;

    // slots beyond the index field can never be written
    assign wr_hit = i_wr.en && (SLOT_ID < (1 << SLOT_W)) && (i_wr.index == SLOT_W'(SLOT_ID));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_hit) begin
            r_valid <= i_wr.in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_proto    <= i_wr.protocol;
            r_loc_set  <= i_wr.local_set;
            r_loc_addr <= i_wr.local_addr;
            r_rem_set  <= i_wr.remote_set;
            r_rem_addr <= i_wr.remote_addr;
        end
    end

    assign proto_eq = (r_proto == i_tok.proto);
    assign loc_hit  = r_loc_set && (r_loc_addr == i_tok.dst);
    assign rem_hit  = r_rem_set && (r_rem_addr == i_tok.src);
    assign no_addr  = !r_loc_set && !r_rem_set;

    always_comb begin
        level = LEVEL_NONE;
        priority if (!r_valid) begin
            level = LEVEL_NONE;
        end else if (proto_eq && rem_hit && loc_hit) begin
            level = LEVEL_FULL;
        end else if (proto_eq && ((rem_hit && !r_loc_set) || (loc_hit && !r_rem_set))) begin
            level = LEVEL_ONE_ADDR;
        end else if (proto_eq && no_addr) begin
            level = LEVEL_PROTO;
        end else if ((r_proto == '0) && no_addr) begin
            level = LEVEL_CATCHALL;
        end
    end

    // strictly greater keeps the lower slot on a tie
    always_comb begin
        n_tok = i_tok;
        if (level > i_tok.level) begin
            n_tok.level = level;
            n_tok.slot  = SLOT_W'(SLOT_ID);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= n_tok.valid;
        end
        if (i_adv) begin
            r_tok.src   <= n_tok.src;
            r_tok.dst   <= n_tok.dst;
            r_tok.proto <= n_tok.proto;
            r_tok.level <= n_tok.level;
            r_tok.slot  <= n_tok.slot;
        end
    end

    assign o_tok = r_tok;

endmodule
